// ===== hw/rtl/voxel_ray_traversal_top_assert.svh =====
// Assertion macros for the checker of the voxel ray traversal block.
`ifndef VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// The consequent must hold in the cycle after the antecedent.
`define VRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

// ===== hw/rtl/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel ray traversal package
// Types and constants shared by the controller, the datapath and the checker.
// ----------------------------------------------------------------------------
package vrt_pkg;

   typedef enum logic [1:0] {
      STATUS_MISS     = 2'd0,
      STATUS_HIT      = 2'd1,
      STATUS_ZERO_DIR = 2'd2,
      STATUS_WRITE    = 2'd3
   } status_type;

   localparam logic [1:0] FACE_NONE = 2'd0;

   localparam int T_W    = 33;
   localparam int Q_W    = 31;
   localparam int CELL_W = 10;
   localparam int DIV_STEPS = 31;
   localparam logic [2:0] DIV_LAST_SEL = 3'd5;
   localparam logic [T_W-1:0] T_INF = {T_W{1'b1}};

   typedef struct packed {
      logic       load;
      logic       wr;
      logic       clr;
      logic       div_start;
      logic [2:0] div_sel;
      logic       rd;
      logic       step;
      logic       res_load;
      status_type res_status;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic alive;
      logic in_grid;
      logic solid;
      logic over;
      logic is_write;
      logic zero_dir;
   } stat_type;

endpackage

// ===== hw/rtl/vrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Voxel ray traversal controller
// Sequences the clearing pass, writes, the setup divisions, the cell walk and the result hand-off.
// ----------------------------------------------------------------------------
module vrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  vrt_pkg::stat_type stat,
   output vrt_pkg::cmd_type  cmd
);
   import vrt_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_WALK, ST_LOOK, ST_RESULT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] sel_ff, sel_in;
   status_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      res_in   = res_ff;
      cmd      = '0;
      cmd.res_status = res_ff;
      cmd.div_sel    = sel_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (stat.is_write) begin
                  cmd.wr   = 1'b1;
                  res_in   = STATUS_WRITE;
                  state_in = ST_RESULT;
               end else if (stat.zero_dir) begin
                  res_in   = STATUS_ZERO_DIR;
                  state_in = ST_RESULT;
               end else begin
                  cmd.load      = 1'b1;
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = 3'd0;
                  sel_in        = 3'd0;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               if (sel_ff == DIV_LAST_SEL) begin
                  state_in = ST_WALK;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = sel_ff + 3'd1;
                  sel_in        = sel_ff + 3'd1;
               end
            end
         end
         ST_WALK: begin
            if (!stat.alive) begin
               res_in   = STATUS_MISS;
               state_in = ST_RESULT;
            end else if (stat.in_grid) begin
               cmd.rd   = 1'b1;
               state_in = ST_LOOK;
            end else if (stat.over) begin
               res_in   = STATUS_MISS;
               state_in = ST_RESULT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_LOOK: begin
            if (stat.solid) begin
               res_in   = STATUS_HIT;
               state_in = ST_RESULT;
            end else if (stat.over) begin
               res_in   = STATUS_MISS;
               state_in = ST_RESULT;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_RESULT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.res_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sel_ff       <= 3'd0;
         res_ff       <= STATUS_MISS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/vrt_datapath.sv =====
// ----------------------------------------------------------------------------
// Voxel ray traversal datapath
// Occupancy memory, shared bit-serial divider, per-axis walk registers and
// the result register.
// ----------------------------------------------------------------------------
module vrt_datapath #(
   parameter int GRID = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  vrt_pkg::cmd_type    cmd,
   output vrt_pkg::stat_type   stat,
   input  logic                req_type,
   input  logic [5:0]          req_wr_x,
   input  logic [5:0]          req_wr_y,
   input  logic [5:0]          req_wr_z,
   input  logic                req_wr_solid,
   input  logic signed [15:0]  req_origin_x,
   input  logic signed [15:0]  req_origin_y,
   input  logic signed [15:0]  req_origin_z,
   input  logic signed [15:0]  req_dir_x,
   input  logic signed [15:0]  req_dir_y,
   input  logic signed [15:0]  req_dir_z,
   input  logic [15:0]         req_max_length,
   output vrt_pkg::status_type rsp_status,
   output logic [5:0]          rsp_hit_x,
   output logic [5:0]          rsp_hit_y,
   output logic [5:0]          rsp_hit_z,
   output logic [1:0]          rsp_face_axis,
   output logic                rsp_face_negative
);
   import vrt_pkg::*;

   localparam int CELLS = GRID * GRID * GRID;
   localparam int AW = $clog2(CELLS);
   localparam logic signed [CELL_W-1:0] GRID_C = CELL_W'(GRID);

   logic occ_mem [CELLS];
   logic [AW-1:0] clr_cnt_ff;
   logic rd_data_ff;
   logic [AW-1:0] wr_addr, walk_addr;
   logic wr_inside;

   logic signed [15:0] org [3];
   logic signed [15:0] dir [3];
   logic [8:0] dist_in [3];
   logic signed [CELL_W-1:0] cell_ff [3];
   logic pos_ff [3];
   logic zero_ff [3];
   logic [15:0] mag_ff [3];
   logic [8:0] dist_ff [3];
   logic [T_W-1:0] tmax_ff [3];
   logic [Q_W-1:0] tdelta_ff [3];
   logic [23:0] limit_ff;
   logic [1:0] face_ff;
   logic neg_ff;

   logic [Q_W-1:0] num_ff;
   logic [15:0] rem_ff;
   logic [15:0] dvs_ff;
   logic [4:0] cnt_ff;
   logic busy_ff;
   logic [2:0] dsel_ff;
   logic [16:0] trial;
   logic qbit;
   logic [Q_W-1:0] quot;
   logic [1:0] dax;
   logic [1:0] sax;

   logic [2:0] ax_alive, ax_in;
   logic [1:0] pick;

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dist_in[k] = dir[k][15] ? 9'd256 - {1'b0, 8'(-org[k][7:0])}
                                 : 9'd256 - {1'b0, org[k][7:0]};
      end
   end

   assign wr_inside = (32'(req_wr_x) < GRID) && (32'(req_wr_y) < GRID)
                      && (32'(req_wr_z) < GRID);
   assign wr_addr = AW'((32'(req_wr_x) * GRID + 32'(req_wr_y)) * GRID + 32'(req_wr_z));
   assign walk_addr = AW'((32'(cell_ff[0][CELL_W-2:0]) * GRID
                     + 32'(cell_ff[1][CELL_W-2:0])) * GRID
                     + 32'(cell_ff[2][CELL_W-2:0]));

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         occ_mem[clr_cnt_ff] <= 1'b0;
      end else if (cmd.wr && wr_inside) begin
         occ_mem[wr_addr] <= req_wr_solid;
      end
      if (cmd.rd) begin
         rd_data_ff <= occ_mem[walk_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign trial = {rem_ff, num_ff[Q_W-1]};
   assign qbit  = (trial >= {1'b0, dvs_ff});
   assign quot  = {num_ff[Q_W-2:0], qbit};
   assign dax   = dsel_ff[2:1];
   assign sax   = cmd.div_sel[2:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dsel_ff <= cmd.div_sel;
         rem_ff  <= '0;
         dvs_ff  <= cmd.load ? (dir[0][15] ? 16'(-dir[0]) : dir[0]) : mag_ff[sax];
         num_ff  <= cmd.div_sel[0] ? (Q_W'(1) << 30)
                  : {cmd.load ? dist_in[0] : dist_ff[sax], 22'd0};
      end else if (busy_ff) begin
         rem_ff <= qbit ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         num_ff <= quot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            cell_ff[k] <= CELL_W'(signed'(org[k][15:8]));
            pos_ff[k]  <= ~dir[k][15] && (dir[k] != 16'sd0);
            zero_ff[k] <= (dir[k] == 16'sd0);
            mag_ff[k]  <= dir[k][15] ? 16'(-dir[k]) : dir[k];
            dist_ff[k] <= dist_in[k];
         end
         limit_ff <= {req_max_length, 8'd0};
         face_ff  <= FACE_NONE;
         neg_ff   <= 1'b0;
      end else if (busy_ff && cnt_ff == 5'(DIV_STEPS - 1)) begin
         if (dsel_ff[0]) begin
            tdelta_ff[dax] <= quot;
         end else begin
            tmax_ff[dax] <= zero_ff[dax] ? T_INF : T_W'(quot);
         end
      end else if (cmd.step) begin
         cell_ff[pick] <= pos_ff[pick] ? cell_ff[pick] + CELL_W'(1)
                                       : cell_ff[pick] - CELL_W'(1);
         tmax_ff[pick] <= tmax_ff[pick] + T_W'(tdelta_ff[pick]);
         face_ff       <= pick + 2'd1;
         neg_ff        <= pos_ff[pick];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ax_alive[k] = pos_ff[k] ? (cell_ff[k] < GRID_C) : (cell_ff[k] >= 0);
         ax_in[k]    = (cell_ff[k] >= 0) && (cell_ff[k] < GRID_C);
      end
      if (tmax_ff[0] < tmax_ff[1]) begin
         pick = (tmax_ff[0] < tmax_ff[2]) ? 2'd0 : 2'd2;
      end else begin
         pick = (tmax_ff[1] < tmax_ff[2]) ? 2'd1 : 2'd2;
      end
   end

   assign stat.clr_last = (32'(clr_cnt_ff) == CELLS - 1);
   assign stat.div_done = busy_ff && (cnt_ff == 5'(DIV_STEPS - 1));
   assign stat.alive    = &ax_alive;
   assign stat.in_grid  = &ax_in;
   assign stat.solid    = rd_data_ff;
   assign stat.over     = tmax_ff[pick] > T_W'(limit_ff);
   assign stat.is_write = ~req_type;
   assign stat.zero_dir = (req_dir_x == 16'sd0) && (req_dir_y == 16'sd0)
                          && (req_dir_z == 16'sd0);

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_status <= cmd.res_status;
         if (cmd.res_status == STATUS_HIT) begin
            rsp_hit_x         <= cell_ff[0][5:0];
            rsp_hit_y         <= cell_ff[1][5:0];
            rsp_hit_z         <= cell_ff[2][5:0];
            rsp_face_axis     <= face_ff;
            rsp_face_negative <= neg_ff;
         end else begin
            rsp_hit_x         <= '0;
            rsp_hit_y         <= '0;
            rsp_hit_z         <= '0;
            rsp_face_axis     <= FACE_NONE;
            rsp_face_negative <= 1'b0;
         end
      end
   end

endmodule

// ===== hw/rtl/voxel_ray_traversal_top.sv =====
// A write item updates the occupancy memory when it is taken. A cast item first runs
// six divisions on the shared divider for its setup, then walks the cells, with one
// occupancy read for each cell inside the grid and none for a cell outside it.
// One item is in work at a time; the result register frees the input side.
// After reset a clearing pass over all GRID^3 cells (262144 at GRID = 64) empties the
// occupancy memory, and no item is taken until it ends.
// ----------------------------------------------------------------------------
// Voxel ray traversal top level
// Occupancy bitmap with a 3-D DDA ray walk reporting the first solid cell.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_top #(
   parameter int GRID = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [5:0]          req_wr_x,
   input  logic [5:0]          req_wr_y,
   input  logic [5:0]          req_wr_z,
   input  logic                req_wr_solid,
   input  logic signed [15:0]  req_origin_x,
   input  logic signed [15:0]  req_origin_y,
   input  logic signed [15:0]  req_origin_z,
   input  logic signed [15:0]  req_dir_x,
   input  logic signed [15:0]  req_dir_y,
   input  logic signed [15:0]  req_dir_z,
   input  logic [15:0]         req_max_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output vrt_pkg::status_type rsp_status,
   output logic [5:0]          rsp_hit_x,
   output logic [5:0]          rsp_hit_y,
   output logic [5:0]          rsp_hit_z,
   output logic [1:0]          rsp_face_axis,
   output logic                rsp_face_negative
);
   import vrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   vrt_datapath #(.GRID(GRID)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_wr_x          (req_wr_x),
      .req_wr_y          (req_wr_y),
      .req_wr_z          (req_wr_z),
      .req_wr_solid      (req_wr_solid),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_origin_z      (req_origin_z),
      .req_dir_x         (req_dir_x),
      .req_dir_y         (req_dir_y),
      .req_dir_z         (req_dir_z),
      .req_max_length    (req_max_length),
      .rsp_status        (rsp_status),
      .rsp_hit_x         (rsp_hit_x),
      .rsp_hit_y         (rsp_hit_y),
      .rsp_hit_z         (rsp_hit_z),
      .rsp_face_axis     (rsp_face_axis),
      .rsp_face_negative (rsp_face_negative)
   );

endmodule

// ===== hw/rtl/vrt_checker.sv =====
// ----------------------------------------------------------------------------
// Voxel ray traversal checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "voxel_ray_traversal_top_assert.svh"

module vrt_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input vrt_pkg::status_type rsp_status,
   input logic [5:0]          rsp_hit_x,
   input logic [1:0]          rsp_face_axis
);
   import vrt_pkg::*;

   `VRT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `VRT_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `VRT_ASSERT_SAME(a_plain_result, clock, reset, rsp_valid && rsp_status != STATUS_HIT, rsp_hit_x == 6'd0 && rsp_face_axis == FACE_NONE)

endmodule

bind voxel_ray_traversal_top vrt_checker u_vrt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_hit_x     (rsp_hit_x),
   .rsp_face_axis (rsp_face_axis)
);

// ===== test/voxel_ray_traversal_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voxel ray traversal testbench
// Loads occupancy cells and casts rays through the grid. Each result is
// checked against a cell-by-cell walk that this bench keeps on its own copy
// of the occupancy bitmap. The run uses random idling on both sides, two long
// result hold-offs and a pause that lets the block drain.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_top_tb;
   import vrt_pkg::*;

   localparam int GRID = 64;
   localparam int N_RANDOM = 1900;

   typedef struct {
      bit              cast;
      bit [5:0]        wx, wy, wz;
      bit              solid;
      bit signed [15:0] org [3];
      bit signed [15:0] dir [3];
      bit [15:0]       len;
      bit              drain;
   } ray_req_type;

   typedef struct {
      status_type status;
      bit [5:0]   hx, hy, hz;
      bit [1:0]   face;
      bit         neg;
   } ray_rsp_type;

   logic clock, reset;
   logic req_valid, req_stall, req_type, req_wr_solid;
   logic [5:0] req_wr_x, req_wr_y, req_wr_z;
   logic signed [15:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [15:0] req_dir_x, req_dir_y, req_dir_z;
   logic [15:0] req_max_length;
   logic rsp_valid, rsp_stall, rsp_face_negative;
   status_type rsp_status;
   logic [5:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic [1:0] rsp_face_axis;

   voxel_ray_traversal_top #(.GRID(GRID)) i_dut (.*);

   bit          occ_map [0:GRID*GRID*GRID-1];
   ray_req_type pending_reqs [$];
   ray_rsp_type expected_rsps [$];
   ray_req_type offered;
   int          accepted_cnt, send_idle, recv_idle, hold_cnt;
   bit          hold1_done, hold2_done, failed;

   function automatic bit axis_alive(int c, int s);
      return s > 0 ? c < GRID : c >= 0;
   endfunction

   function automatic ray_rsp_type walk_ray(ray_req_type r);
      ray_rsp_type res;
      int cpos [3], stp [3];
      longint unsigned tmx [3], tdl [3], limit, mag, dst;
      int o, d, a;
      bit [1:0] face;
      bit neg;
      res = '{STATUS_MISS, 0, 0, 0, FACE_NONE, 0};
      face = FACE_NONE;
      neg = 0;
      if (!r.cast) begin
         occ_map[(r.wx * GRID + r.wy) * GRID + r.wz] = r.solid;
         res.status = STATUS_WRITE;
         return res;
      end
      if (r.dir[0] == 0 && r.dir[1] == 0 && r.dir[2] == 0) begin
         res.status = STATUS_ZERO_DIR;
         return res;
      end
      for (int k = 0; k < 3; k++) begin
         o = r.org[k];
         d = r.dir[k];
         cpos[k] = o >>> 8;
         if (d == 0) begin
            stp[k] = 0;
            tmx[k] = '1;
            tdl[k] = 0;
         end else begin
            stp[k] = d > 0 ? 1 : -1;
            mag = d > 0 ? d : -d;
            dst = d > 0 ? 256 - (o & 255) : 256 - ((-o) & 255);
            tmx[k] = (dst << 22) / mag;
            tdl[k] = (64'd1 << 30) / mag;
         end
      end
      limit = longint'(r.len) << 8;
      while (axis_alive(cpos[0], stp[0]) && axis_alive(cpos[1], stp[1]) &&
             axis_alive(cpos[2], stp[2])) begin
         if (cpos[0] >= 0 && cpos[0] < GRID && cpos[1] >= 0 && cpos[1] < GRID &&
             cpos[2] >= 0 && cpos[2] < GRID &&
             occ_map[(cpos[0] * GRID + cpos[1]) * GRID + cpos[2]]) begin
            res = '{STATUS_HIT, cpos[0][5:0], cpos[1][5:0], cpos[2][5:0], face, neg};
            return res;
         end
         if (tmx[0] < tmx[1]) a = tmx[0] < tmx[2] ? 0 : 2;
         else a = tmx[1] < tmx[2] ? 1 : 2;
         if (tmx[a] > limit) break;
         cpos[a] += stp[a];
         tmx[a] += tdl[a];
         face = a + 1;
         neg = stp[a] > 0;
      end
      return res;
   endfunction

   function automatic ray_req_type wr_req(int x, int y, int z, bit s);
      ray_req_type r;
      r = '{0, x, y, z, s, '{0, 0, 0}, '{0, 0, 0}, 0, 0};
      return r;
   endfunction

   function automatic ray_req_type cast_req(int ox, int oy, int oz, int dx, int dy,
                                            int dz, int len);
      ray_req_type r;
      r = '{1, 0, 0, 0, 0, '{ox, oy, oz}, '{dx, dy, dz}, len, 0};
      return r;
   endfunction

   function automatic int rand_dir();
      if ($urandom_range(99) < 15) return 0;
      return int'($urandom_range(32768)) - 16384;
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("voxel_ray_traversal_top: mismatch");
      $finish;
   end

   always_comb begin
      if (accepted_cnt < 700) begin
         send_idle = 22;
         recv_idle = 54;
      end else if (accepted_cnt < 1400) begin
         send_idle = 54;
         recv_idle = 22;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(walk_ray(offered));
            accepted_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 &&
                !(pending_reqs[0].drain && expected_rsps.size() > 0) &&
                $urandom_range(99) >= send_idle) begin
               offered = pending_reqs.pop_front();
               req_valid <= 1;
               req_type <= offered.cast;
               req_wr_x <= offered.wx;
               req_wr_y <= offered.wy;
               req_wr_z <= offered.wz;
               req_wr_solid <= offered.solid;
               req_origin_x <= offered.org[0];
               req_origin_y <= offered.org[1];
               req_origin_z <= offered.org[2];
               req_dir_x <= offered.dir[0];
               req_dir_y <= offered.dir[1];
               req_dir_z <= offered.dir[2];
               req_max_length <= offered.len;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1;
      end else if (!hold1_done && accepted_cnt >= 400) begin
         hold1_done <= 1;
         hold_cnt <= 3000;
         rsp_stall <= 1;
      end else if (!hold2_done && accepted_cnt >= 1500) begin
         hold2_done <= 1;
         hold_cnt <= 3000;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle;
      end
   end

   always @(posedge clock) begin
      ray_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected item, status %0d", $time, rsp_status);
            failed = 1;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_status !== exp_rsp.status || rsp_hit_x !== exp_rsp.hx ||
                rsp_hit_y !== exp_rsp.hy || rsp_hit_z !== exp_rsp.hz ||
                rsp_face_axis !== exp_rsp.face ||
                rsp_face_negative !== exp_rsp.neg) begin
               $display("%0t: expected st %0d hit %0d,%0d,%0d face %0d neg %0d, got st %0d hit %0d,%0d,%0d face %0d neg %0d",
                        $time, exp_rsp.status, exp_rsp.hx, exp_rsp.hy, exp_rsp.hz,
                        exp_rsp.face, exp_rsp.neg, rsp_status, rsp_hit_x, rsp_hit_y,
                        rsp_hit_z, rsp_face_axis, rsp_face_negative);
               failed = 1;
            end
         end
      end
   end

   initial begin
      ray_req_type r;
      int lo;
      req_valid = 0;
      rsp_stall = 0;
      req_type = 0;
      req_wr_x = 0;
      req_wr_y = 0;
      req_wr_z = 0;
      req_wr_solid = 0;
      req_origin_x = 0;
      req_origin_y = 0;
      req_origin_z = 0;
      req_dir_x = 0;
      req_dir_y = 0;
      req_dir_z = 0;
      req_max_length = 0;
      reset = 1;

      // Directed part: grid corners, zero direction, origin-cell hit, origins
      // outside the grid, a zero length limit and non-unit directions.
      pending_reqs.push_back(wr_req(0, 0, 0, 1));
      pending_reqs.push_back(wr_req(63, 63, 63, 1));
      pending_reqs.push_back(wr_req(63, 0, 63, 1));
      pending_reqs.push_back(wr_req(63, 0, 63, 0));
      pending_reqs.push_back(cast_req(128, 128, 128, 0, 0, 0, 65535));
      pending_reqs.push_back(cast_req(128, 128, 128, 16384, 0, 0, 65535));
      pending_reqs.push_back(cast_req(-2688, 128, 128, 16384, 0, 0, 65535));
      pending_reqs.push_back(cast_req(16000, 128, 128, -16384, 0, 0, 65535));
      pending_reqs.push_back(cast_req(256, 256, 256, 9459, 9459, 9459, 65535));
      pending_reqs.push_back(cast_req(32767, 32767, 32767, -9459, -9459, -9459, 65535));
      pending_reqs.push_back(cast_req(-32768, -32768, -32768, 9459, 9459, 9459, 65535));
      pending_reqs.push_back(cast_req(-32768, 128, 128, 16384, 0, 0, 65535));
      pending_reqs.push_back(cast_req(32767, 128, 128, 16384, 0, 0, 65535));
      pending_reqs.push_back(cast_req(1280, 128, 128, -16384, 0, 0, 0));
      pending_reqs.push_back(cast_req(1280, 128, 128, -16384, 0, 0, 2560));
      pending_reqs.push_back(cast_req(1280, 128, 128, -1, 0, 0, 65535));
      pending_reqs.push_back(cast_req(16128, 16128, 16128, 0, 0, 16384, 65535));
      pending_reqs.push_back(cast_req(16128, 16128, 2560, 0, 0, 16384, 65535));
      pending_reqs.push_back(cast_req(16128, 2560, 16128, 0, 16384, 0, 65535));
      pending_reqs.push_back(cast_req(256, 256, 256, -16384, -16384, -16384, 65535));
      pending_reqs.push_back(wr_req(0, 0, 0, 0));

      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(99) < 40) begin
            if ($urandom_range(99) < 70)
               r = wr_req($urandom_range(39, 24), $urandom_range(39, 24),
                          $urandom_range(39, 24), $urandom_range(99) < 85);
            else
               r = wr_req($urandom_range(63), $urandom_range(63), $urandom_range(63),
                          $urandom_range(1));
         end else begin
            lo = $urandom_range(99);
            if (lo < 15)
               r = cast_req($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), rand_dir(), rand_dir(), rand_dir(),
                            $urandom_range(65535));
            else
               r = cast_req($urandom_range(16383), $urandom_range(16383),
                            $urandom_range(16383), rand_dir(), rand_dir(), rand_dir(),
                            lo < 30 ? $urandom_range(4095) : $urandom_range(65535));
            if ($urandom_range(99) < 3) r.dir = '{0, 0, 0};
         end
         r.drain = (n == 900);
         pending_reqs.push_back(r);
      end

      repeat (8) @(posedge clock);
      reset <= 0;
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (1000) @(posedge clock);
      if (!failed && expected_rsps.size() == 0)
         $display("voxel_ray_traversal_top: match");
      else
         $display("voxel_ray_traversal_top: mismatch");
      $finish;
   end

endmodule
